>>> rtl/upsc_pkg.sv
// Shared types, constants and helpers for the integer pixel upscaler.
// No dependencies; every other file of the block but upsc_ram imports it.
package upsc_pkg;

   // default sizing handed to the top level parameters, and the queue depth
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_SCALE = 64;
   localparam int QUEUE_DEPTH   = 4;

   // register file geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SCALE_W     = 7;
   localparam int SRC_WIDTH_W = 11;
   localparam int SRC_HEIGHT_W = 16;
   localparam int PIXEL_W     = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd2;

   // item kinds
   localparam logic OP_PIXEL  = 1'b0;
   localparam logic OP_REPLAY = 1'b1;

   // input word
   typedef struct packed {
      logic       opcode;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } upsc_req_type;

   // result word
   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       row_end;
      logic [1:0] pad_bytes;
      logic       run_last;
      logic       image_end;
      logic       order_error;
   } upsc_rsp_type;

   // command from the front end to the output expander
   typedef struct packed {
      logic                err;
      logic [PIXEL_W-1:0]  pix;       // {red, green, blue}
      logic                row_end;
      logic [1:0]          pad;
      logic                img_end;
   } upsc_cmd_type;

   // front end to queue handoff
   typedef struct packed {
      logic         push;
      upsc_cmd_type cmd;
   } upsc_push_type;

   // row padding: (4 - (w*f*3) mod 4) mod 4 reduces to (w*f) mod 4
   function automatic logic [1:0] pad_count(input logic [1:0] w_lo, input logic [1:0] f_lo);
      logic [3:0] prod;
      prod = {2'b00, w_lo} * {2'b00, f_lo};
      return prod[1:0];
   endfunction

endpackage

>>> rtl/upsc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module upsc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/upsc_front.sv
// Front end: accepts words, checks item kind, tracks column/copy/row and
// drives the line buffer. Depends on upsc_pkg and upsc_ram.
module upsc_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  logic                                 req_push,
   input  upsc_pkg::upsc_req_type               req_data,
   output logic                                 req_full,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       eff_width,
   input  logic [$clog2(MAX_SCALE+1)-1:0]       eff_scale,
   input  logic [upsc_pkg::SRC_HEIGHT_W-1:0]    eff_height,
   input  logic [1:0]                           row_pad,
   input  logic                                 q_full,
   output upsc_pkg::upsc_push_type              q_push
);
   import upsc_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int FW = $clog2(MAX_SCALE + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int HW = SRC_HEIGHT_W;

   logic [AW-1:0] col_ff, col_in;
   logic [CW-1:0] copy_ff, copy_in;
   logic [HW-1:0] row_ff, row_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_replay_ff, s1_replay_in;
   upsc_cmd_type  s1_cmd_ff, s1_cmd_in;

   logic          accept, kind_err, col_last, copy_last, row_last, advance;
   logic [PIXEL_W-1:0] in_pix, rd_pix;

   // stage register drains into the queue when there is room
   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;

   // classify against the expected kind
   assign kind_err  = (copy_ff == '0) != (req_data.opcode == OP_PIXEL);
   assign advance   = accept && !kind_err;
   assign in_pix    = {req_data.red, req_data.green, req_data.blue};
   assign col_last  = ((WW+1)'(col_ff) + (WW+1)'(1)) == (WW+1)'(eff_width);
   assign copy_last = ((FW+1)'(copy_ff) + (FW+1)'(1)) == (FW+1)'(eff_scale);
   assign row_last  = ((HW+1)'(row_ff) + (HW+1)'(1)) == (HW+1)'(eff_height);

   // line buffer: written on the first copy, read back on replays
   upsc_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (advance && (req_data.opcode == OP_PIXEL)),
      .wr_addr (col_ff),
      .wr_data (in_pix),
      .rd_en   (advance && (req_data.opcode == OP_REPLAY)),
      .rd_addr (col_ff),
      .rd_data (rd_pix)
   );

   // position counters
   always_comb begin
      col_in  = col_ff;
      copy_in = copy_ff;
      row_in  = row_ff;
      if (clear) begin
         col_in  = '0;
         copy_in = '0;
         row_in  = '0;
      end else if (advance) begin
         if (!col_last) begin
            col_in = AW'(col_ff + 1'b1);
         end else begin
            col_in = '0;
            if (!copy_last) begin
               copy_in = CW'(copy_ff + 1'b1);
            end else begin
               copy_in = '0;
               row_in  = row_last ? '0 : HW'(row_ff + 1'b1);
            end
         end
      end
   end

   // stage register contents
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_replay_in = s1_replay_ff;
      s1_cmd_in    = s1_cmd_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_replay_in = !kind_err && (req_data.opcode == OP_REPLAY);
         s1_cmd_in.err     = kind_err;
         s1_cmd_in.pix     = kind_err ? '0 : in_pix;
         s1_cmd_in.row_end = !kind_err && col_last;
         s1_cmd_in.pad     = (!kind_err && col_last) ? row_pad : 2'd0;
         s1_cmd_in.img_end = !kind_err && col_last && copy_last && row_last;
      end else if (q_push.push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         copy_ff     <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         copy_ff     <= copy_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_replay_ff <= s1_replay_in;
      s1_cmd_ff    <= s1_cmd_in;
   end

   // replay words take the pixel from the buffer read
   always_comb begin
      q_push.push = s1_valid_ff && !q_full;
      q_push.cmd  = s1_cmd_ff;
      if (s1_replay_ff) begin
         q_push.cmd.pix = rd_pix;
      end
   end

endmodule

>>> rtl/upsc_queue.sv
// Short command queue between front end and output expander.
// Depends on upsc_pkg.
module upsc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  upsc_pkg::upsc_push_type wr,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output upsc_pkg::upsc_cmd_type  rd_cmd
);
   import upsc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   upsc_cmd_type  entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full   = count_ff == NW'(DEPTH);
   assign empty  = count_ff == '0;
   assign do_wr  = wr.push && !full;
   assign do_rd  = pop && !empty;
   assign rd_cmd = entry_ff[rd_ptr_ff];

   // pointer wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr.cmd;
      end
   end

endmodule

>>> rtl/upsc_back.sv
// Output expander: repeats each good command's pixel scale-factor times
// (error commands once), holds the current result word. Depends on upsc_pkg.
module upsc_back #(
   parameter int MAX_SCALE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_SCALE+1)-1:0]    eff_scale,
   input  logic                              q_empty,
   input  upsc_pkg::upsc_cmd_type            q_cmd,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output upsc_pkg::upsc_rsp_type            rsp_data
);
   import upsc_pkg::*;

   localparam int FW = $clog2(MAX_SCALE + 1);
   localparam int CW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

   logic          busy_ff, busy_in;
   logic [CW-1:0] rep_ff, rep_in;
   upsc_cmd_type  cur_ff, cur_in;
   logic          last, take, done;

   assign last  = cur_ff.err || (((FW+1)'(rep_ff) + (FW+1)'(1)) == (FW+1)'(eff_scale));
   assign take  = rsp_pop && busy_ff;
   assign done  = take && last;
   assign q_pop = !q_empty && (!busy_ff || done);

   // load next command as the current one finishes
   always_comb begin
      busy_in = busy_ff;
      rep_in  = rep_ff;
      cur_in  = cur_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         rep_in  = '0;
         cur_in  = q_cmd;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         rep_in = CW'(rep_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rep_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rep_ff  <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result word; row and image marks only on the last copy
   assign rsp_empty            = !busy_ff;
   assign rsp_data.out_blue    = cur_ff.pix[7:0];
   assign rsp_data.out_green   = cur_ff.pix[15:8];
   assign rsp_data.out_red     = cur_ff.pix[23:16];
   assign rsp_data.row_end     = last && cur_ff.row_end;
   assign rsp_data.pad_bytes   = (last && cur_ff.row_end) ? cur_ff.pad : 2'd0;
   assign rsp_data.run_last    = last;
   assign rsp_data.image_end   = last && cur_ff.img_end;
   assign rsp_data.order_error = cur_ff.err;

endmodule

>>> rtl/integer_pixel_upscaler.sv
// Top level of the integer pixel upscaler: register file, front end,
// command queue and output expander. Depends on upsc_pkg and submodules.
//
// Usage:
//  - Input queue: drive req_data and raise req_push; a word is taken on a
//    clock edge with req_push high and req_full low. Send each source row
//    once as pixel words, then scale_factor-1 times as replay words.
//  - Result queue: while rsp_empty is low, rsp_data holds the oldest
//    result; it is taken on an edge with rsp_pop high.
//  - Each good word gives scale_factor results, one per cycle unless the
//    receiver stalls; a word of the wrong kind gives one result with
//    order_error set and no effect.
//  - Path: front-end stage register, command queue, output expander.
//  - Throughput: one result per cycle while rsp_pop is high; the output
//    expander sets this, and the front end takes up to five words ahead
//    while the result side is busy.
//  - If the receiver stalls, the result word holds and words pile up in
//    the queue until req_full rises.
//  - csr_we writes a register and restarts the image position; write only
//    while the block is idle.
//  - Reset empties the pipeline, clears positions and sets all registers
//    to 1; the line buffer needs no clearing pass.
module integer_pixel_upscaler #(
   parameter int MAX_WIDTH = upsc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = upsc_pkg::DEF_MAX_SCALE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  upsc_pkg::upsc_req_type            req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output upsc_pkg::upsc_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [upsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [upsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import upsc_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int FW = $clog2(MAX_SCALE + 1);

   logic [SCALE_W-1:0]      scale_ff, scale_in;
   logic [SRC_WIDTH_W-1:0]  width_ff, width_in;
   logic [SRC_HEIGHT_W-1:0] height_ff, height_in;
   logic                    clear;

   logic [FW-1:0]           eff_scale;
   logic [WW-1:0]           eff_width;
   logic [SRC_HEIGHT_W-1:0] eff_height;
   logic [1:0]              row_pad;

   upsc_push_type           q_wr;
   upsc_cmd_type            q_cmd;
   logic                    q_full, q_empty, q_pop;

   // register writes
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      clear     = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_SCALE: begin
               scale_in = csr_wdata[SCALE_W-1:0];
               clear    = 1'b1;
            end
            CSR_WIDTH: begin
               width_in = csr_wdata[SRC_WIDTH_W-1:0];
               clear    = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[SRC_HEIGHT_W-1:0];
               clear     = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(1);
         width_ff  <= SRC_WIDTH_W'(1);
         height_ff <= SRC_HEIGHT_W'(1);
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamp registers to their working ranges
   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = FW'(1);
      end else if (32'(scale_ff) > 32'(MAX_SCALE)) begin
         eff_scale = FW'(MAX_SCALE);
      end else begin
         eff_scale = FW'(scale_ff);
      end
      if (width_ff == '0) begin
         eff_width = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ff);
      end
      eff_height = (height_ff == '0) ? SRC_HEIGHT_W'(1) : height_ff;
   end

   assign row_pad = pad_count(eff_width[1:0] & 2'(WW > 1 ? 3 : 1),
                              eff_scale[1:0] & 2'(FW > 1 ? 3 : 1));

   upsc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .eff_width  (eff_width),
      .eff_scale  (eff_scale),
      .eff_height (eff_height),
      .row_pad    (row_pad),
      .q_full     (q_full),
      .q_push     (q_wr)
   );

   upsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (q_wr),
      .full   (q_full),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_cmd (q_cmd)
   );

   upsc_back #(
      .MAX_SCALE (MAX_SCALE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eff_scale (eff_scale),
      .q_empty   (q_empty),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/upsc_checker.sv
// Port-level checks for the integer pixel upscaler, bound to the top.
// Depends on upsc_pkg and integer_pixel_upscaler.
module upsc_port_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  upsc_pkg::upsc_rsp_type rsp_data
);
   import upsc_pkg::*;

   // reset leaves no result behind
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // error word is a single bare result
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.order_error) |->
         (rsp_data.run_last && !rsp_data.row_end && !rsp_data.image_end
          && rsp_data.pad_bytes == 2'd0))
      else $error("malformed order error word");

   // image end only on a row end that closes its run
   a_img_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.image_end) |-> (rsp_data.row_end && rsp_data.run_last))
      else $error("image end outside a row end");

   // padding only at row end, row end only on last copy
   a_pad_row: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.pad_bytes != 2'd0 || rsp_data.row_end)) |->
         (rsp_data.row_end && rsp_data.run_last))
      else $error("padding or row end on an inner copy");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind integer_pixel_upscaler upsc_port_checker u_upsc_port_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
